// ----- src/tccs_pkg.sv -----
// Shared types and constants for the text console cursor and scroll engine.
package tccs_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [3:0] FG_RESET = 4'd10;
    localparam logic [3:0] BG_RESET = 4'd0;

    typedef enum logic [2:0] {
        ACT_PUT     = 3'd0,
        ACT_SET     = 3'd1,
        ACT_SAVE    = 3'd2,
        ACT_RESTORE = 3'd3,
        ACT_READ    = 3'd4
    } t_action;

    typedef enum logic {
        REG_FG = 1'b0,
        REG_BG = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ADDR,
        S_READ,
        S_RDATA,
        S_WRITE,
        S_SCROLL,
        S_SLAST,
        S_FILL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] fg;
        logic [3:0] bg;
    } t_cell;

    typedef struct packed {
        logic [4:0] pos_row;
        logic [6:0] pos_col;
        t_cell      rd_cell;
        logic       scrolled;
    } t_result;

endpackage

// ----- src/tccs_cell_ram.sv -----
// Cell store: one write port and one registered read port.
module tccs_cell_ram #(
    parameter int DEPTH = tccs_pkg::ROWS_DEF * tccs_pkg::COLS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tccs_pkg::t_cell i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output tccs_pkg::t_cell o_rdata
);
    import tccs_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tccs_seq.sv -----
// Sequencer: cursor state, address unit and the copy/fill loop over the cell store.
module tccs_seq #(
    parameter int ROWS = tccs_pkg::ROWS_DEF,
    parameter int COLS = tccs_pkg::COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_char_code,
    input  logic [4:0]        i_target_row,
    input  logic [6:0]        i_target_col,
    input  logic [3:0]        i_fg,
    input  logic [3:0]        i_bg,
    input  logic              i_take,
    output logic              o_done,
    output tccs_pkg::t_result o_result
);
    import tccs_pkg::*;

    localparam int NUM_CELLS = ROWS * COLS;
    localparam int AW = $clog2(NUM_CELLS);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);

    t_state          r_state, n_state;
    t_action         r_act, n_act;
    logic [7:0]      r_ch, n_ch;
    logic [7:0]      r_wch, n_wch;
    logic [RW-1:0]   r_trow, n_trow;
    logic [CW-1:0]   r_tcol, n_tcol;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_srow, n_srow;
    logic [CW-1:0]   r_scol, n_scol;
    logic [AW-1:0]   r_addr, n_addr;
    logic [AW-1:0]   r_src, n_src;
    logic [AW-1:0]   r_dst, n_dst;
    logic            r_pend, n_pend;
    logic            r_scr, n_scr;
    t_cell           r_cell, n_cell;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    t_cell           mem_wdata;
    t_cell           mem_rdata;

    logic            row_last;
    logic            col_last;
    logic            col_zero;
    logic            src_last;
    logic            dst_last;
    logic [RW-1:0]   trow_clamp;
    logic [CW-1:0]   tcol_clamp;
    logic [RW-1:0]   addr_row;
    logic [CW-1:0]   addr_col;

    assign row_last = (r_row == RW'(ROWS - 1));
    assign col_last = (r_col == CW'(COLS - 1));
    assign col_zero = (r_col == '0);
    assign src_last = (r_src == AW'(NUM_CELLS - 1));
    assign dst_last = (r_dst == AW'(NUM_CELLS - 1));

    assign trow_clamp = (int'(i_target_row) > ROWS - 1) ? RW'(ROWS - 1) : RW'(i_target_row);
    assign tcol_clamp = (int'(i_target_col) > COLS - 1) ? CW'(COLS - 1) : CW'(i_target_col);

    assign addr_row = (r_act == ACT_READ) ? r_trow : r_row;
    assign addr_col = (r_act == ACT_READ) ? r_tcol : r_col;

    tccs_cell_ram #(
        .DEPTH (NUM_CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == AW'(NUM_CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_item_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (r_act)
                    ACT_PUT: begin
                        priority if (r_ch == CH_NEWLINE) begin
                            n_state = row_last ? S_SCROLL : S_DONE;
                        end else if (r_ch == CH_BACKSPACE) begin
                            n_state = col_zero ? S_DONE : S_ADDR;
                        end else begin
                            n_state = S_ADDR;
                        end
                    end
                    ACT_READ: n_state = S_ADDR;
                    default:  n_state = S_DONE;
                endcase
            end
            S_ADDR:  n_state = (r_act == ACT_READ) ? S_READ : S_WRITE;
            S_READ:  n_state = S_RDATA;
            S_RDATA: n_state = S_DONE;
            S_WRITE: begin
                if (r_ch != CH_BACKSPACE && col_last && row_last) n_state = S_SCROLL;
                else n_state = S_DONE;
            end
            S_SCROLL: begin
                if (src_last) n_state = S_SLAST;
            end
            S_SLAST: n_state = S_FILL;
            S_FILL: begin
                if (dst_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_act  = r_act;
        n_ch   = r_ch;
        n_wch  = r_wch;
        n_trow = r_trow;
        n_tcol = r_tcol;
        n_row  = r_row;
        n_col  = r_col;
        n_srow = r_srow;
        n_scol = r_scol;
        n_addr = r_addr;
        n_src  = r_src;
        n_dst  = r_dst;
        n_pend = r_pend;
        n_scr  = r_scr;
        n_cell = r_cell;
        unique case (r_state)
            S_CLEAR: n_addr = r_addr + 1'b1;
            S_IDLE: begin
                if (i_item_valid) begin
                    n_act  = t_action'(i_action);
                    n_ch   = i_char_code;
                    n_trow = trow_clamp;
                    n_tcol = tcol_clamp;
                    n_cell = '0;
                    n_scr  = 1'b0;
                end
            end
            S_EXEC: begin
                // scroll pointers: source starts one row down
                n_src  = AW'(COLS);
                n_dst  = '0;
                n_pend = 1'b0;
                unique case (r_act)
                    ACT_PUT: begin
                        priority if (r_ch == CH_NEWLINE) begin
                            n_col = '0;
                            if (row_last) n_scr = 1'b1;
                            else n_row = r_row + 1'b1;
                        end else if (r_ch == CH_BACKSPACE) begin
                            if (!col_zero) n_col = r_col - 1'b1;
                            n_wch = CH_SPACE;
                        end else begin
                            n_wch = r_ch;
                        end
                    end
                    ACT_SET: begin
                        n_row = r_trow;
                        n_col = r_tcol;
                    end
                    ACT_SAVE: begin
                        n_srow = r_row;
                        n_scol = r_col;
                    end
                    ACT_RESTORE: begin
                        n_row = r_srow;
                        n_col = r_scol;
                    end
                    default: ;
                endcase
            end
            S_ADDR: n_addr = AW'(int'(addr_row) * COLS + int'(addr_col));
            S_READ: ;
            S_RDATA: n_cell = mem_rdata;
            S_WRITE: begin
                if (r_ch != CH_BACKSPACE) begin
                    if (col_last) begin
                        n_col = '0;
                        if (row_last) n_scr = 1'b1;
                        else n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            S_SCROLL: begin
                n_src  = r_src + 1'b1;
                n_pend = 1'b1;
                if (r_pend) n_dst = r_dst + 1'b1;
            end
            S_SLAST: n_dst = r_dst + 1'b1;
            S_FILL:  n_dst = r_dst + 1'b1;
            S_DONE: ;
            default: ;
        endcase
    end

    // memory drive and handshake outputs
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_dst;
        mem_wdata = '0;
        mem_raddr = r_src;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
            end
            S_READ: mem_raddr = r_addr;
            S_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = '{ch: r_wch, fg: i_fg, bg: i_bg};
            end
            S_SCROLL: begin
                // each write stores the cell read in the previous cycle
                mem_we    = r_pend;
                mem_wdata = mem_rdata;
            end
            S_SLAST: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = '{ch: CH_SPACE, fg: i_fg, bg: i_bg};
            end
            default: ;
        endcase
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_done       = (r_state == S_DONE);

    assign o_result.pos_row  = 5'(r_row);
    assign o_result.pos_col  = 7'(r_col);
    assign o_result.rd_cell  = r_cell;
    assign o_result.scrolled = r_scr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_srow  <= '0;
            r_scol  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_row   <= n_row;
            r_col   <= n_col;
            r_srow  <= n_srow;
            r_scol  <= n_scol;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_ch   <= n_ch;
        r_wch  <= n_wch;
        r_trow <= n_trow;
        r_tcol <= n_tcol;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_scr  <= n_scr;
        r_cell <= n_cell;
    end

endmodule

// ----- src/text_console_cursor_scroll_core.sv -----
// Top level: configuration registers, sequencer and result register.
//
// Character-cell console engine with a ROWS x COLS cell store, a cursor and a
// saved cursor. Each word carries one action (put character, set cursor, save
// cursor, restore cursor, read cell) and yields one result word. After reset
// the block clears the cell store one cell per cycle before it raises
// o_ready; configuration writes are taken throughout. Items are handled one at
// a time by a small sequencer around a single-port-write, registered-read cell
// memory: set, save, restore and unknown actions pass from EXEC to DONE, put
// character goes through ADDR and WRITE (a newline, or a backspace in column
// 0, goes straight to DONE or SCROLL) and read cell through ADDR, READ and
// RDATA; the sequencer returns to IDLE for the next word once DONE hands its
// result to the output register. A newline or line wrap on the last row
// scrolls: every cell is moved up one row through the memory port and the
// bottom row is filled with spaces. A finished result sits in an output
// register, so the next word is accepted while it waits to be taken.
module text_console_cursor_scroll_core #(
    parameter int ROWS = tccs_pkg::ROWS_DEF,
    parameter int COLS = tccs_pkg::COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [4:0]  i_target_row,
    input  logic [6:0]  i_target_col,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_cursor_row_out,
    output logic [6:0]  o_cursor_col_out,
    output logic [7:0]  o_cell_char,
    output logic [3:0]  o_cell_fg,
    output logic [3:0]  o_cell_bg,
    output logic        o_scrolled
);
    import tccs_pkg::*;

    logic [3:0] r_fg;
    logic [3:0] r_bg;
    logic       r_out_valid;
    t_result    r_out;
    logic       take;
    logic       seq_done;
    t_result    seq_result;
    logic       cfg_wr;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (reg_idx)
            REG_FG: prdata = {28'd0, r_fg};
            REG_BG: prdata = {28'd0, r_bg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FG: r_fg <= pwdata[3:0];
                REG_BG: r_bg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // result register frees when empty or being taken
    assign take = !r_out_valid || i_ready;

    tccs_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_valid),
        .o_item_ready (o_ready),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_target_row (i_target_row),
        .i_target_col (i_target_col),
        .i_fg         (r_fg),
        .i_bg         (r_bg),
        .i_take       (take),
        .o_done       (seq_done),
        .o_result     (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done && take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done && take) begin
            r_out <= seq_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_cursor_row_out = r_out.pos_row;
    assign o_cursor_col_out = r_out.pos_col;
    assign o_cell_char      = r_out.rd_cell.ch;
    assign o_cell_fg        = r_out.rd_cell.fg;
    assign o_cell_bg        = r_out.rd_cell.bg;
    assign o_scrolled       = r_out.scrolled;

endmodule

// ----- dv/text_console_cursor_scroll_check.sv -----
// Port monitor for the console engine: tracks screen, cursor and colors, checks each result word.
`timescale 1ns / 1ps

module text_console_cursor_scroll_check #(
    parameter int ROWS = tccs_pkg::ROWS_DEF,
    parameter int COLS = tccs_pkg::COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [4:0]  i_target_row,
    input  logic [6:0]  i_target_col,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [4:0]  o_cursor_row_out,
    input  logic [6:0]  o_cursor_col_out,
    input  logic [7:0]  o_cell_char,
    input  logic [3:0]  o_cell_fg,
    input  logic [3:0]  o_cell_bg,
    input  logic        o_scrolled,
    output int          o_mismatches,
    output int          o_pending
);
    import tccs_pkg::*;

    localparam logic [2:0] FG_ADDR = {REG_FG, 2'b00};
    localparam logic [2:0] BG_ADDR = {REG_BG, 2'b00};

    t_cell      screen [ROWS*COLS];
    int         cur_row, cur_col, mark_row, mark_col;
    logic [3:0] fg_now, bg_now;
    t_result    due_results [$];
    int         mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            report($sformatf("%s got %0d, want %0d", name, got, want));
        end
    endtask

    function automatic void store_cell(int r, int c, logic [7:0] ch);
        screen[r*COLS + c] = {ch, fg_now, bg_now};
    endfunction

    // Move to column 0 of the next row; on the last row shift the screen up.
    function automatic logic next_line();
        cur_col = 0;
        if (cur_row >= ROWS - 1) begin
            cur_row = ROWS - 1;
            for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
                screen[i] = screen[i + COLS];
            end
            for (int c = 0; c < COLS; c++) begin
                store_cell(ROWS - 1, c, CH_SPACE);
            end
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    task automatic step_console(input logic [2:0] act, input logic [7:0] ch,
                                input logic [4:0] trow, input logic [6:0] tcol);
        int      r;
        int      c;
        t_result res;
        r = (int'(trow) > ROWS - 1) ? ROWS - 1 : int'(trow);
        c = (int'(tcol) > COLS - 1) ? COLS - 1 : int'(tcol);
        res = '0;
        case (act)
            ACT_PUT: begin
                if (ch == CH_NEWLINE) begin
                    res.scrolled = next_line();
                end else if (ch == CH_BACKSPACE) begin
                    if (cur_col != 0) begin
                        cur_col--;
                        store_cell(cur_row, cur_col, CH_SPACE);
                    end
                end else begin
                    store_cell(cur_row, cur_col, ch);
                    cur_col++;
                    if (cur_col >= COLS) begin
                        res.scrolled = next_line();
                    end
                end
            end
            ACT_SET: begin
                cur_row = r;
                cur_col = c;
            end
            ACT_SAVE: begin
                mark_row = cur_row;
                mark_col = cur_col;
            end
            ACT_RESTORE: begin
                cur_row = mark_row;
                cur_col = mark_col;
            end
            ACT_READ: begin
                res.rd_cell = screen[r*COLS + c];
            end
            default: ;
        endcase
        res.pos_row = cur_row[4:0];
        res.pos_col = cur_col[6:0];
        due_results.push_back(res);
    endtask

    always @(posedge i_clk) begin : watch_ports
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS * COLS; i++) begin
                screen[i] = '0;
            end
            cur_row  = 0;
            cur_col  = 0;
            mark_row = 0;
            mark_col = 0;
            fg_now   = FG_RESET;
            bg_now   = BG_RESET;
            due_results.delete();
            o_pending <= 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == FG_ADDR) fg_now = pwdata[3:0];
                    if (paddr == BG_ADDR) bg_now = pwdata[3:0];
                end else if (paddr == FG_ADDR) begin
                    check_field("fg_color read", prdata, {28'd0, fg_now});
                end else if (paddr == BG_ADDR) begin
                    check_field("bg_color read", prdata, {28'd0, bg_now});
                end
            end
            // the result taken at this edge cannot belong to a word taken at the same edge
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    report("result word with nothing pending");
                end else begin
                    want = due_results.pop_front();
                    check_field("cursor_row_out", int'(o_cursor_row_out), int'(want.pos_row));
                    check_field("cursor_col_out", int'(o_cursor_col_out), int'(want.pos_col));
                    check_field("cell_char", int'(o_cell_char), int'(want.rd_cell.ch));
                    check_field("cell_fg", int'(o_cell_fg), int'(want.rd_cell.fg));
                    check_field("cell_bg", int'(o_cell_bg), int'(want.rd_cell.bg));
                    check_field("scrolled", int'(o_scrolled), int'(want.scrolled));
                end
            end
            if (i_valid && o_ready) begin
                step_console(i_action, i_char_code, i_target_row, i_target_col);
            end
            o_pending <= due_results.size();
        end
    end

endmodule

// ----- dv/text_console_cursor_scroll_core_test.sv -----
// Top of the console engine bench: clock, reset, stimulus, color phases and verdict.
`timescale 1ns / 1ps

module text_console_cursor_scroll_core_test;
    import tccs_pkg::*;

    localparam int LIMIT       = 20_000_000;
    localparam int PHASE_WORDS = 310;
    localparam int IDLE_PAUSE  = 8;
    localparam int END_WAIT    = 64;
    localparam int HOLD_CYCLES = 400;

    localparam logic [2:0] FG_ADDR = {REG_FG, 2'b00};
    localparam logic [2:0] BG_ADDR = {REG_BG, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_action = '0;
    logic [7:0]  i_char_code = '0;
    logic [4:0]  i_target_row = '0;
    logic [6:0]  i_target_col = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [4:0]  o_cursor_row_out;
    logic [6:0]  o_cursor_col_out;
    logic [7:0]  o_cell_char;
    logic [3:0]  o_cell_fg;
    logic [3:0]  o_cell_bg;
    logic        o_scrolled;

    int   mismatches;
    int   pending;
    int   cycle_count = 0;
    int   words_sent = 0;
    int   rx_stall = 0;
    logic no_gaps = 1'b0;
    logic hold_off_req = 1'b0;
    logic hold_off_done = 1'b0;

    text_console_cursor_scroll_core dut (.*);

    text_console_cursor_scroll_check u_check (
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .*
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: mostly ready, short stalls, a few long ones, one long hold-off.
    always @(posedge i_clk) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            i_ready  <= 1'b0;
        end else if (hold_off_req && !hold_off_done) begin
            hold_off_done <= 1'b1;
            rx_stall      <= HOLD_CYCLES;
            i_ready       <= 1'b0;
        end else if (no_gaps || pick < 70) begin
            i_ready <= 1'b1;
        end else begin
            i_ready  <= 1'b0;
            rx_stall <= (pick < 96) ? $urandom_range(0, 3) : $urandom_range(20, 90);
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 60) return 0;
        if (pick < 95) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [4:0] rand_row();
        return ($urandom_range(0, 3) == 0) ? 5'(ROWS_DEF - 1) : 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [6:0] rand_col();
        return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(COLS_DEF - 8, COLS_DEF - 1))
                                           : 7'($urandom_range(0, 127));
    endfunction

    // Offer one word and hold it until taken; valid stays up when no gap follows.
    task automatic send_word(input logic [2:0] act, input logic [7:0] ch,
                             input logic [4:0] row, input logic [6:0] col);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_char_code  <= ch;
        i_target_row <= row;
        i_target_col <= col;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= {28'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        apb_access(1'b1, FG_ADDR, fg);
        apb_access(1'b1, BG_ADDR, bg);
        apb_access(1'b0, FG_ADDR, '0);
        apb_access(1'b0, BG_ADDR, '0);
    endtask

    // Drop valid and wait until every result word has come back.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic text_burst();
        int n;
        if ($urandom_range(0, 1)) send_word(ACT_SET, 8'($urandom), rand_row(), rand_col());
        n = $urandom_range(1, 12);
        repeat (n) begin
            send_word(ACT_PUT,
                      ($urandom_range(0, 9) == 0) ? CH_BACKSPACE : 8'($urandom_range(0, 255)),
                      5'($urandom), 7'($urandom));
        end
        if ($urandom_range(0, 1)) send_word(ACT_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom));
    endtask

    task automatic mark_burst();
        int n;
        send_word(ACT_SAVE, 8'($urandom), 5'($urandom), 7'($urandom));
        send_word(ACT_SET, 8'($urandom), rand_row(), rand_col());
        n = $urandom_range(1, 4);
        repeat (n) begin
            send_word(ACT_PUT, 8'($urandom_range(0, 255)), 5'($urandom), 7'($urandom));
        end
        send_word(ACT_RESTORE, 8'($urandom), 5'($urandom), 7'($urandom));
        send_word(ACT_READ, 8'($urandom), rand_row(), rand_col());
    endtask

    task automatic run_phase(input int words);
        int target;
        int n;
        target = words_sent + words;
        while (words_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: text_burst();
                4, 5:       mark_burst();
                6, 7: begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_word(ACT_READ, 8'($urandom), rand_row(), rand_col());
                end
                default: send_word(3'($urandom_range(0, 7)), 8'($urandom),
                                   5'($urandom), 7'($urandom));
            endcase
        end
    endtask

    initial begin
        logic [3:0] fg_pick;
        logic [3:0] bg_pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset contents, clamping, char zero, backspace, wrap, scroll, save/restore and unknown actions
        send_word(ACT_READ, '0, 5'd0, 7'd0);
        send_word(ACT_READ, '0, 5'd31, 7'd127);
        send_word(ACT_PUT, "A", '0, '0);
        send_word(ACT_READ, '0, 5'd0, 7'd0);
        send_word(ACT_PUT, 8'h00, '0, '0);
        send_word(ACT_PUT, 8'hFF, '0, '0);
        send_word(ACT_PUT, CH_BACKSPACE, '0, '0);
        send_word(ACT_READ, '0, 5'd0, 7'd2);
        send_word(ACT_SET, '0, 5'd0, 7'd0);
        send_word(ACT_PUT, CH_BACKSPACE, '0, '0);
        send_word(ACT_SET, '0, 5'd31, 7'd127);
        send_word(ACT_SAVE, '0, '0, '0);
        send_word(ACT_PUT, 8'h7E, '0, '0);
        send_word(ACT_READ, '0, 5'd23, 7'd79);
        send_word(ACT_READ, '0, 5'd24, 7'd0);
        send_word(ACT_RESTORE, '0, '0, '0);
        send_word(ACT_PUT, CH_NEWLINE, '0, '0);
        send_word(ACT_SET, '0, 5'd2, 7'd78);
        send_word(ACT_PUT, "x", '0, '0);
        send_word(ACT_PUT, "y", '0, '0);
        send_word(ACT_PUT, CH_NEWLINE, '0, '0);
        for (int a = ACT_READ + 1; a < 8; a++) begin
            send_word(3'(a), 8'hFF, 5'd31, 7'd127);
        end
        send_word(ACT_READ, '0, 5'd2, 7'd79);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       begin fg_pick = 4'hF; bg_pick = 4'hF; end
                1:       begin fg_pick = 4'h0; bg_pick = 4'h0; end
                2:       begin fg_pick = 4'hF; bg_pick = 4'h0; end
                3:       begin fg_pick = 4'h0; bg_pick = 4'hF; end
                default: begin
                    fg_pick = 4'($urandom_range(0, 15));
                    bg_pick = 4'($urandom_range(0, 15));
                end
            endcase
            set_colors(fg_pick, bg_pick);
            if (p == 1) hold_off_req <= 1'b1;
            no_gaps <= (p == 2);
            run_phase(PHASE_WORDS);
            drain();
        end

        repeat (END_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/tccs_pkg.sv
src/tccs_cell_ram.sv
src/tccs_seq.sv
src/text_console_cursor_scroll_core.sv
dv/text_console_cursor_scroll_check.sv
dv/text_console_cursor_scroll_core_test.sv
